// ===== hdl/csq_pkg.sv =====
package csq_pkg;

    // Operation codes carried on the slave-side tuser
    typedef enum logic [1:0] {
        MODE_OPEN   = 2'd0,
        MODE_WAIT   = 2'd1,
        MODE_SIGNAL = 2'd2,
        MODE_CLOSE  = 2'd3
    } t_mode;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_BLOCKED  = 2'd1,
        ST_NOT_OPEN = 2'd2,
        ST_FULL     = 2'd3
    } t_status;

    // Sequencer states
    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_EXEC   = 4'b0010,
        S_DRAIN  = 4'b0100,
        S_RDWAIT = 4'b1000
    } t_state;

    // Commands from the sequencer to the waiter queue
    typedef struct packed {
        logic clear;
        logic push;
        logic pop;
    } t_q_cmd;

    // Queue occupancy flags back to the sequencer
    typedef struct packed {
        logic empty;
        logic one;
        logic full;
    } t_q_stat;

    localparam int CountW   = 18;
    localparam int CntOutW  = 17;
    localparam int InitW    = 16;
    localparam int TidW     = 8;
    localparam logic signed [CountW-1:0] COUNT_MAX = 18'sd65535;

endpackage

// ===== hdl/csq_waitq.sv =====
module csq_waitq
    import csq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16,
    parameter int ID_W        = 8
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  t_q_cmd          i_cmd,
    input  logic [ID_W-1:0] i_push_id,
    output logic [ID_W-1:0] o_head_id,
    output t_q_stat         o_stat
);

    localparam int PtrW  = $clog2(QUEUE_DEPTH);
    localparam int FillW = $clog2(QUEUE_DEPTH + 1);

    logic [ID_W-1:0]  r_mem [QUEUE_DEPTH];
    logic [ID_W-1:0]  r_head_id;
    logic [PtrW-1:0]  r_head, r_tail;
    logic [FillW-1:0] r_fill;
    logic [PtrW-1:0]  n_head_inc, n_tail_inc;

    // Wrap pointers at the queue depth
    assign n_head_inc = (r_head == PtrW'(QUEUE_DEPTH - 1)) ? '0 : r_head + 1'b1;
    assign n_tail_inc = (r_tail == PtrW'(QUEUE_DEPTH - 1)) ? '0 : r_tail + 1'b1;

    // Write the pushed id at the tail
    always_ff @(posedge i_clk) begin
        if (i_cmd.push && !i_cmd.clear) begin
            r_mem[r_tail] <= i_push_id;
        end
    end

    // Read the oldest waiter continuously into a register behind the head pointer
    always_ff @(posedge i_clk) begin
        r_head_id <= r_mem[r_head];
    end

    // Advance pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0;
            r_tail <= '0;
            r_fill <= '0;
        end else if (i_cmd.clear) begin
            r_head <= '0;
            r_tail <= '0;
            r_fill <= '0;
        end else if (i_cmd.push) begin
            r_tail <= n_tail_inc;
            r_fill <= r_fill + 1'b1;
        end else if (i_cmd.pop) begin
            r_head <= n_head_inc;
            r_fill <= r_fill - 1'b1;
        end
    end

    assign o_head_id    = r_head_id;
    assign o_stat.empty = (r_fill == '0);
    assign o_stat.one   = (r_fill == FillW'(1));
    assign o_stat.full  = (r_fill == FillW'(QUEUE_DEPTH));

endmodule

// ===== hdl/counting_semaphore_wait_queue_core.sv =====
// Counting semaphore with a FIFO of blocked thread ids.
// Slave stream: tuser[1:0] carries the operation (open, wait, signal, close);
// tdata carries the caller's thread id and its finished flag. The master
// stream returns one result per operation (status, wake flag, woken thread,
// count after the operation), and tlast marks the final result of an item.
// Close returns one result per queued waiter, oldest first.
// The cfg channel loads initial_count, used by the next open; write it only
// while no operation is in flight.
// An operation is taken in S_IDLE and executed in S_EXEC, which registers
// its result once the output register is free. A close with waiters
// alternates S_DRAIN and S_RDWAIT, which waits for the registered read of
// the waiter memory between pops.
// The next operation is taken while the last result still sits in the output
// register; a stalled master holds that result and stops the sequencer
// before it produces another one.
// Reset: closed, count zero, queue empty, initial_count zero. The waiter
// memory is not cleared; the fill count covers its contents.
module counting_semaphore_wait_queue_core
    import csq_pkg::*;
#(
    parameter int QUEUE_DEPTH    = 16,
    parameter int THREAD_ID_BITS = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration write
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_data,    // initial_count
    // Operation stream
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [15:0] i_s_tdata,     // [7:0] thread_id, [8] thread_finished
    input  logic [1:0]  i_s_tuser,     // [1:0] mode
    // Result stream
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [31:0] o_m_tdata,     // [1:0] status, [2] wake_valid,
                                       // [10:3] wake_thread, [27:11] count_after
    output logic        o_m_tlast      // last
);

    localparam int IdW = (THREAD_ID_BITS < TidW) ? THREAD_ID_BITS : TidW;
    localparam logic signed [CountW-1:0] NegDepth = -(CountW'(QUEUE_DEPTH));

    t_state                    r_state, n_state;
    t_mode                     r_mode;
    logic [IdW-1:0]            r_tid;
    logic                      r_fin;
    logic [InitW-1:0]          r_init_cnt;
    logic signed [CountW-1:0]  r_count, n_count;
    logic                      r_open, n_open;

    logic signed [CountW-1:0]  cnt_dec, cnt_inc;
    logic                      out_free;
    logic                      emit, e_wake, e_last;
    t_status                   e_status;

    t_q_cmd                    q_cmd;
    t_q_stat                   q_stat;
    logic [IdW-1:0]            q_head_id;

    logic                      r_ovalid;
    t_status                   r_ostatus;
    logic                      r_owake;
    logic [TidW-1:0]           r_othread;
    logic [CntOutW-1:0]        r_ocount;
    logic                      r_olast;

    csq_waitq #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .ID_W        (IdW)
    ) u_waitq (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (q_cmd),
        .i_push_id (r_tid),
        .o_head_id (q_head_id),
        .o_stat    (q_stat)
    );

    // Configuration register
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_init_cnt <= '0;
        end else if (i_cfg_valid) begin
            r_init_cnt <= i_cfg_data;
        end
    end

    // Take one operation at a time
    assign o_s_tready = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (i_s_tvalid && o_s_tready) begin
            r_mode <= t_mode'(i_s_tuser);
            r_tid  <= i_s_tdata[IdW-1:0];
            r_fin  <= i_s_tdata[8];
        end
    end

    assign cnt_dec  = r_count - 1'b1;
    assign cnt_inc  = (r_count < COUNT_MAX) ? r_count + 1'b1 : r_count;
    assign out_free = !r_ovalid || i_m_tready;

    // Sequencer: read-modify-write of count and queue
    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_open   = r_open;
        q_cmd    = '0;
        emit     = 1'b0;
        e_status = ST_OK;
        e_wake   = 1'b0;
        e_last   = 1'b1;
        unique case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (out_free) begin
                    n_state = S_IDLE;
                    emit    = 1'b1;
                    if (r_mode == MODE_OPEN) begin
                        n_count     = {{(CountW-InitW){1'b0}}, r_init_cnt};
                        q_cmd.clear = 1'b1;
                        n_open      = 1'b1;
                    end else if (!r_open) begin
                        e_status = ST_NOT_OPEN;
                    end else if (r_mode == MODE_WAIT) begin
                        if (cnt_dec >= 18'sd0) begin
                            n_count = cnt_dec;
                        end else if (cnt_dec < NegDepth || (!r_fin && q_stat.full)) begin
                            e_status = ST_FULL;
                        end else if (r_fin) begin
                            n_count = cnt_dec;
                        end else begin
                            n_count    = cnt_dec;
                            q_cmd.push = 1'b1;
                            e_status   = ST_BLOCKED;
                        end
                    end else if (r_mode == MODE_SIGNAL) begin
                        n_count = cnt_inc;
                        if (cnt_inc <= 18'sd0 && !q_stat.empty) begin
                            q_cmd.pop = 1'b1;
                            e_wake    = 1'b1;
                        end
                    end else begin
                        // Close: drain waiters, or finish at once when none
                        if (q_stat.empty) begin
                            q_cmd.clear = 1'b1;
                            n_open      = 1'b0;
                        end else begin
                            emit    = 1'b0;
                            n_state = S_DRAIN;
                        end
                    end
                end
            end
            S_DRAIN: begin
                if (out_free) begin
                    emit      = 1'b1;
                    e_wake    = 1'b1;
                    q_cmd.pop = 1'b1;
                    e_last    = q_stat.one;
                    if (q_stat.one) begin
                        q_cmd.clear = 1'b1;
                        n_open      = 1'b0;
                        n_state     = S_IDLE;
                    end else begin
                        n_state = S_RDWAIT;
                    end
                end
            end
            S_RDWAIT: begin
                n_state = S_DRAIN;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Hold control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_open  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_open  <= n_open;
        end
    end

    // Output register: load on emit, drop after the transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (emit) begin
            r_ovalid <= 1'b1;
        end else if (i_m_tready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_ostatus <= e_status;
            r_owake   <= e_wake;
            r_othread <= e_wake ? TidW'(q_head_id) : '0;
            r_ocount  <= n_count[CntOutW-1:0];
            r_olast   <= e_last;
        end
    end

    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = {4'b0000, r_ocount, r_othread, r_owake, r_ostatus};
    assign o_m_tlast  = r_olast;

    // Never push into a full queue
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_cmd.push |-> !q_stat.full)
        else $error("push into full waiter queue");

    // Count stays within the queue's reach below zero
    a_count_floor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count >= NegDepth)
        else $error("semaphore count below queue depth");

    // Draining only happens on an open semaphore with waiters left
    a_drain_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DRAIN) |-> (!q_stat.empty && r_open))
        else $error("drain with empty queue or closed semaphore");

    // A pop always reports a woken thread in the next result
    a_pop_wakes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (q_cmd.pop && !q_cmd.clear && emit) |=> (r_ovalid && r_owake))
        else $error("pop without wake result");

endmodule
